// ----- rtl/jsu_pkg.sv -----
// jsu_pkg: shared types and constants for the json string unescape block
`default_nettype none

package jsu_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_NO_QUOTE   = 3'd1,
		ERR_BAD_HEX    = 3'd2,
		ERR_BAD_SURR   = 3'd3,
		ERR_BAD_LOW    = 3'd4,
		ERR_BAD_ESCAPE = 3'd5,
		ERR_CTRL_CHAR  = 3'd6,
		ERR_UNTERM     = 3'd7
	} err_t;

	// decoder phase
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_STR  = 4'd1,
		PH_ESC  = 4'd2,
		PH_HI0  = 4'd3,
		PH_HI1  = 4'd4,
		PH_HI2  = 4'd5,
		PH_HI3  = 4'd6,
		PH_BSL  = 4'd7,
		PH_U    = 4'd8,
		PH_LO0  = 4'd9,
		PH_LO1  = 4'd10,
		PH_LO2  = 4'd11,
		PH_LO3  = 4'd12
	} phase_t;

	// one queued command: a single result, or a code point to encode
	typedef struct packed {
		kind_t       kind;
		err_t        code;
		logic        raw;   // copy cp[7:0] through unchanged
		logic [20:0] cp;
	} cmd_t;

	// text characters
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// surrogate bounds and utf-8 framing
	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] PAIR_BASE   = 21'h10000;
	localparam logic [20:0] CP_MAX1     = 21'h7F;
	localparam logic [20:0] CP_MAX2     = 21'h7FF;
	localparam logic [20:0] CP_MAX3     = 21'hFFFF;
	localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
	localparam logic [7:0]  UTF8_LEAD4  = 8'hF0;
	localparam logic [7:0]  UTF8_CONT   = 8'h80;

endpackage

`default_nettype wire

// ----- rtl/jsu_in_if.sv -----
// jsu_in_if: valid/ready channel carrying raw json text bytes
`default_nettype none

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_input;

	modport source (output valid, output text_byte, output end_of_input, input ready);
	modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsu_out_if.sv -----
// jsu_out_if: valid/ready channel carrying decoded result items
`default_nettype none

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, output out_byte, output kind, output error_code,
		output last, input ready);
	modport sink (input valid, input out_byte, input kind, input error_code,
		input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// jsu_front: per-byte phase machine that classifies text and queues commands
`default_nettype none

module jsu_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	jsu_in_if.sink          text,
	input  wire logic       full,
	output logic            push,
	output jsu_pkg::cmd_t   push_cmd
);

	jsu_pkg::phase_t phase_q;
	jsu_pkg::phase_t phase_d;
	logic [15:0]     high_q;
	logic [15:0]     low_q;

	logic        accept;
	logic [7:0]  c;
	logic        eoi;
	logic [4:0]  hx;
	logic        hex_ok;
	logic [3:0]  nib;
	logic [15:0] hi_full;
	logic [15:0] lo_full;
	logic [20:0] pair_cp;
	logic        hi_is_surr;
	logic        lo_is_surr;
	logic        is_hi_digit;
	logic        is_lo_digit;

	// hex digit to {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch >= 8'h30 && ch <= 8'h39)
			r = {1'b1, 4'(ch - 8'h30)};
		else if (ch >= 8'h61 && ch <= 8'h66)
			r = {1'b1, 4'(ch - 8'h57)};
		else if (ch >= 8'h41 && ch <= 8'h46)
			r = {1'b1, 4'(ch - 8'h37)};
		return r;
	endfunction

	assign text.ready = !full;
	assign accept     = text.valid && !full;
	assign c          = text.text_byte;
	assign eoi        = text.end_of_input;

	// digit decode and unit assembly
	assign hx         = hex_val(c);
	assign hex_ok     = hx[4] && !eoi;
	assign nib        = hx[3:0];
	assign hi_full    = {high_q[11:0], nib};
	assign lo_full    = {low_q[11:0], nib};
	assign hi_is_surr = (hi_full >= jsu_pkg::HI_SURR_MIN) && (hi_full <= jsu_pkg::HI_SURR_MAX);
	assign lo_is_surr = (lo_full >= jsu_pkg::LO_SURR_MIN) && (lo_full <= jsu_pkg::LO_SURR_MAX);
	assign pair_cp    = jsu_pkg::PAIR_BASE + {1'b0, high_q[9:0], lo_full[9:0]};

	assign is_hi_digit = (phase_q == jsu_pkg::PH_HI0) || (phase_q == jsu_pkg::PH_HI1) ||
		(phase_q == jsu_pkg::PH_HI2) || (phase_q == jsu_pkg::PH_HI3);
	assign is_lo_digit = (phase_q == jsu_pkg::PH_LO0) || (phase_q == jsu_pkg::PH_LO1) ||
		(phase_q == jsu_pkg::PH_LO2) || (phase_q == jsu_pkg::PH_LO3);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q) inside
				jsu_pkg::PH_STR: begin
					if (eoi || c == jsu_pkg::CH_QUOTE)
						phase_d = jsu_pkg::PH_IDLE;
					else if (c == jsu_pkg::CH_BACKSLASH)
						phase_d = jsu_pkg::PH_ESC;
					else if (c < jsu_pkg::CH_SPACE)
						phase_d = jsu_pkg::PH_IDLE;
				end
				jsu_pkg::PH_ESC: begin
					if (eoi)
						phase_d = jsu_pkg::PH_IDLE;
					else if (c == jsu_pkg::CH_U)
						phase_d = jsu_pkg::PH_HI0;
					else if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH ||
						c == jsu_pkg::CH_SLASH || c == jsu_pkg::CH_B || c == jsu_pkg::CH_F ||
						c == jsu_pkg::CH_N || c == jsu_pkg::CH_R || c == jsu_pkg::CH_T)
						phase_d = jsu_pkg::PH_STR;
					else
						phase_d = jsu_pkg::PH_IDLE;
				end
				jsu_pkg::PH_HI0: phase_d = hex_ok ? jsu_pkg::PH_HI1 : jsu_pkg::PH_IDLE;
				jsu_pkg::PH_HI1: phase_d = hex_ok ? jsu_pkg::PH_HI2 : jsu_pkg::PH_IDLE;
				jsu_pkg::PH_HI2: phase_d = hex_ok ? jsu_pkg::PH_HI3 : jsu_pkg::PH_IDLE;
				jsu_pkg::PH_HI3: begin
					if (!hex_ok)
						phase_d = jsu_pkg::PH_IDLE;
					else if (hi_is_surr)
						phase_d = jsu_pkg::PH_BSL;
					else
						phase_d = jsu_pkg::PH_STR;
				end
				jsu_pkg::PH_BSL: begin
					phase_d = (!eoi && c == jsu_pkg::CH_BACKSLASH) ? jsu_pkg::PH_U
						: jsu_pkg::PH_IDLE;
				end
				jsu_pkg::PH_U: begin
					phase_d = (!eoi && c == jsu_pkg::CH_U) ? jsu_pkg::PH_LO0 : jsu_pkg::PH_IDLE;
				end
				jsu_pkg::PH_LO0: phase_d = hex_ok ? jsu_pkg::PH_LO1 : jsu_pkg::PH_IDLE;
				jsu_pkg::PH_LO1: phase_d = hex_ok ? jsu_pkg::PH_LO2 : jsu_pkg::PH_IDLE;
				jsu_pkg::PH_LO2: phase_d = hex_ok ? jsu_pkg::PH_LO3 : jsu_pkg::PH_IDLE;
				jsu_pkg::PH_LO3: begin
					phase_d = (hex_ok && lo_is_surr) ? jsu_pkg::PH_STR : jsu_pkg::PH_IDLE;
				end
				default: begin
					phase_d = (!eoi && c == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_STR
						: jsu_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// command for the back end
	always_comb begin
		push          = 1'b0;
		push_cmd.kind = jsu_pkg::KIND_DATA;
		push_cmd.code = jsu_pkg::ERR_NONE;
		push_cmd.raw  = 1'b0;
		push_cmd.cp   = '0;
		if (accept) begin
			unique case (phase_q) inside
				jsu_pkg::PH_STR: begin
					if (eoi) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_UNTERM;
					end else if (c == jsu_pkg::CH_QUOTE) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_CLOSE;
					end else if (c == jsu_pkg::CH_BACKSLASH) begin
						push = 1'b0;
					end else if (c < jsu_pkg::CH_SPACE) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_CTRL_CHAR;
					end else begin
						push         = 1'b1;
						push_cmd.raw = 1'b1;
						push_cmd.cp  = {13'd0, c};
					end
				end
				jsu_pkg::PH_ESC: begin
					push = 1'b1;
					if (eoi) begin
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_ESCAPE;
					end else begin
						push_cmd.raw = 1'b1;
						unique case (c)
							jsu_pkg::CH_QUOTE,
							jsu_pkg::CH_BACKSLASH,
							jsu_pkg::CH_SLASH: push_cmd.cp = {13'd0, c};
							jsu_pkg::CH_B:     push_cmd.cp = 21'h08;
							jsu_pkg::CH_F:     push_cmd.cp = 21'h0C;
							jsu_pkg::CH_N:     push_cmd.cp = 21'h0A;
							jsu_pkg::CH_R:     push_cmd.cp = 21'h0D;
							jsu_pkg::CH_T:     push_cmd.cp = 21'h09;
							jsu_pkg::CH_U:     push = 1'b0;
							default: begin
								push_cmd.raw  = 1'b0;
								push_cmd.kind = jsu_pkg::KIND_ERROR;
								push_cmd.code = jsu_pkg::ERR_BAD_ESCAPE;
							end
						endcase
					end
				end
				jsu_pkg::PH_HI0, jsu_pkg::PH_HI1, jsu_pkg::PH_HI2,
				jsu_pkg::PH_LO0, jsu_pkg::PH_LO1, jsu_pkg::PH_LO2: begin
					if (!hex_ok) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_HEX;
					end
				end
				jsu_pkg::PH_HI3: begin
					if (!hex_ok) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_HEX;
					end else if (!hi_is_surr) begin
						push        = 1'b1;
						push_cmd.cp = {5'd0, hi_full};
					end
				end
				jsu_pkg::PH_BSL: begin
					if (eoi || c != jsu_pkg::CH_BACKSLASH) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_SURR;
					end
				end
				jsu_pkg::PH_U: begin
					if (eoi || c != jsu_pkg::CH_U) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_SURR;
					end
				end
				jsu_pkg::PH_LO3: begin
					push = 1'b1;
					if (!hex_ok) begin
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_HEX;
					end else if (!lo_is_surr) begin
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_BAD_LOW;
					end else begin
						push_cmd.cp = pair_cp;
					end
				end
				default: begin
					if (eoi || c != jsu_pkg::CH_QUOTE) begin
						push          = 1'b1;
						push_cmd.kind = jsu_pkg::KIND_ERROR;
						push_cmd.code = jsu_pkg::ERR_NO_QUOTE;
					end
				end
			endcase
		end
	end

	// phase and surrogate unit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_IDLE;
			high_q  <= '0;
			low_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == jsu_pkg::PH_ESC && !eoi && c == jsu_pkg::CH_U)
				high_q <= '0;
			else if (accept && is_hi_digit && hex_ok)
				high_q <= hi_full;
			if (accept && phase_q == jsu_pkg::PH_U && !eoi && c == jsu_pkg::CH_U)
				low_q <= '0;
			else if (accept && is_lo_digit && hex_ok)
				low_q <= lo_full;
		end
	end

	// surrogate pair only forms after a high surrogate unit
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jsu_pkg::PH_BSL) |-> (high_q >= jsu_pkg::HI_SURR_MIN &&
			high_q <= jsu_pkg::HI_SURR_MAX))
		else $error("jsu_front: low unit awaited without a high surrogate");

endmodule

`default_nettype wire

// ----- rtl/jsu_queue.sv -----
// jsu_queue: small command fifo between the front and back ends
`default_nettype none

module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire jsu_pkg::cmd_t  push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output jsu_pkg::cmd_t       head_cmd
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::cmd_t   entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if ((push && !full) && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!(push && !full) && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// the front never offers a command into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("jsu_queue: push while full");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("jsu_queue: fill count overflow");

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// jsu_back: utf-8 encoder that expands queued commands into result transfers
`default_nettype none

module jsu_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire jsu_pkg::cmd_t  head_cmd,
	output logic                pop,
	jsu_out_if.source           result
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  out_kind_q;
	logic [2:0]  out_code_q;
	logic        out_last_q;
	logic [1:0]  idx_q;

	logic        advance;
	logic        encode;
	logic [1:0]  n_m1;
	logic [7:0]  enc [4];
	logic [7:0]  sel_byte;
	logic        is_last;

	assign advance = !out_valid_q || result.ready;
	assign encode  = (head_cmd.kind == jsu_pkg::KIND_DATA) && !head_cmd.raw;

	// last byte index of the head command (byte count minus one)
	always_comb begin
		if (!encode || head_cmd.cp <= jsu_pkg::CP_MAX1)
			n_m1 = 2'd0;
		else if (head_cmd.cp <= jsu_pkg::CP_MAX2)
			n_m1 = 2'd1;
		else if (head_cmd.cp <= jsu_pkg::CP_MAX3)
			n_m1 = 2'd2;
		else
			n_m1 = 2'd3;
	end

	// utf-8 byte split
	always_comb begin
		enc[0] = 8'h00;
		enc[1] = 8'h00;
		enc[2] = 8'h00;
		enc[3] = 8'h00;
		case (n_m1)
			2'd0: begin
				if (head_cmd.kind == jsu_pkg::KIND_DATA)
					enc[0] = head_cmd.cp[7:0];
			end
			2'd1: begin
				enc[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, head_cmd.cp[10:6]};
				enc[1] = jsu_pkg::UTF8_CONT | {2'd0, head_cmd.cp[5:0]};
			end
			2'd2: begin
				enc[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, head_cmd.cp[15:12]};
				enc[1] = jsu_pkg::UTF8_CONT | {2'd0, head_cmd.cp[11:6]};
				enc[2] = jsu_pkg::UTF8_CONT | {2'd0, head_cmd.cp[5:0]};
			end
			default: begin
				enc[0] = jsu_pkg::UTF8_LEAD4 | {5'd0, head_cmd.cp[20:18]};
				enc[1] = jsu_pkg::UTF8_CONT | {2'd0, head_cmd.cp[17:12]};
				enc[2] = jsu_pkg::UTF8_CONT | {2'd0, head_cmd.cp[11:6]};
				enc[3] = jsu_pkg::UTF8_CONT | {2'd0, head_cmd.cp[5:0]};
			end
		endcase
	end

	assign sel_byte = enc[idx_q];
	assign is_last  = (idx_q == n_m1);
	assign pop      = advance && head_valid && is_last;

	// byte index within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_byte_q <= sel_byte;
			out_kind_q <= head_cmd.kind;
			out_code_q <= head_cmd.code;
			out_last_q <= is_last;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.kind       = out_kind_q;
	assign result.error_code = out_code_q;
	assign result.last       = out_last_q;

	// a partly sent code point always has its command still at the head
	assert property (@(posedge clk) disable iff (!arst_n) (idx_q != 2'd0) |-> head_valid)
		else $error("jsu_back: byte index set with empty queue");

	// close and error results are single and final
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q != jsu_pkg::KIND_DATA) |-> (out_last_q && out_byte_q == 8'h00))
		else $error("jsu_back: non-data result not final");

	// error code present exactly on error results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_kind_q == jsu_pkg::KIND_ERROR) == (out_code_q != jsu_pkg::ERR_NONE)))
		else $error("jsu_back: error code does not match kind");

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_core.sv -----
// json_string_unescape_core: top level of the json string literal decoder
// path: an accepted byte's command is written into the queue, then encoded into the output register
// throughput: one text byte per cycle until stalled; a code point sends 1 to 4 bytes, one per ready cycle
// the command queue (QUEUE_DEPTH entries) absorbs multi-byte bursts before input stalls
// reset: arst_n clears the phase to idle, empties the queue and drops the output register
`default_nettype none

module json_string_unescape_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    text,
	jsu_out_if.source result
);

	logic           push;
	jsu_pkg::cmd_t  push_cmd;
	logic           full;
	logic           pop;
	logic           head_valid;
	jsu_pkg::cmd_t  head_cmd;

	// classify input bytes
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decouple front and back
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// encode and deliver results
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

// ----- dv/json_string_unescape_checker.sv -----
// json_string_unescape_checker: watches both channels, predicts decoded output and compares it
`timescale 1ns / 100ps

module json_string_unescape_checker
	import jsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	jsu_in_if    text_ch,
	jsu_out_if   res_ch,
	output int   pending,
	output int   mismatches
);

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		err_t       code;
		logic       last;
	} decoded_t;

	// predicted results not yet seen on the output channel
	decoded_t decoded_q[$];

	// predictor state
	phase_t      dec_phase;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;

	function automatic int hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	task automatic push_result(logic [7:0] data, kind_t kind, err_t code, logic last);
		decoded_q.push_back('{data, kind, code, last});
	endtask

	// any error drops the partial escape and returns to idle
	task automatic raise_error(err_t code);
		dec_phase = PH_IDLE;
		hi_unit   = '0;
		lo_unit   = '0;
		push_result(8'h00, KIND_ERROR, code, 1'b1);
	endtask

	// utf-8 encoding of one code point, 1 to 4 bytes
	task automatic emit_code_point(logic [20:0] cp);
		logic [7:0] b[4];
		int n;
		if (cp <= CP_MAX1) begin
			b[0] = cp[7:0];
			n = 1;
		end else if (cp <= CP_MAX2) begin
			b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			b[1] = UTF8_CONT | {2'b00, cp[5:0]};
			n = 2;
		end else if (cp <= CP_MAX3) begin
			b[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
			b[1] = UTF8_CONT | {2'b00, cp[11:6]};
			b[2] = UTF8_CONT | {2'b00, cp[5:0]};
			n = 3;
		end else begin
			b[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
			b[1] = UTF8_CONT | {2'b00, cp[17:12]};
			b[2] = UTF8_CONT | {2'b00, cp[11:6]};
			b[3] = UTF8_CONT | {2'b00, cp[5:0]};
			n = 4;
		end
		for (int i = 0; i < n; i++)
			push_result(b[i], KIND_DATA, ERR_NONE, i == n - 1);
		dec_phase = PH_STR;
		hi_unit   = '0;
		lo_unit   = '0;
	endtask

	// one accepted text byte through the decoder
	task automatic decode_byte(logic [7:0] c, logic eoi);
		logic [7:0]  v;
		logic        bad;
		int          h;
		logic [20:0] hi_off;
		v   = '0;
		bad = 1'b0;
		h   = eoi ? -1 : hex_value(c);
		case (dec_phase)
			PH_STR: begin
				if (eoi) raise_error(ERR_UNTERM);
				else if (c == CH_QUOTE) begin
					dec_phase = PH_IDLE;
					push_result(8'h00, KIND_CLOSE, ERR_NONE, 1'b1);
				end else if (c == CH_BACKSLASH) dec_phase = PH_ESC;
				else if (c < CH_SPACE) raise_error(ERR_CTRL_CHAR);
				else push_result(c, KIND_DATA, ERR_NONE, 1'b1);
			end
			PH_ESC: begin
				if (eoi) raise_error(ERR_BAD_ESCAPE);
				else if (c == CH_U) begin
					hi_unit   = '0;
					dec_phase = PH_HI0;
				end else begin
					case (c)
						CH_QUOTE, CH_BACKSLASH, CH_SLASH: v = c;
						CH_B: v = 8'h08;
						CH_F: v = 8'h0C;
						CH_N: v = 8'h0A;
						CH_R: v = 8'h0D;
						CH_T: v = 8'h09;
						default: bad = 1'b1;
					endcase
					if (bad) raise_error(ERR_BAD_ESCAPE);
					else begin
						dec_phase = PH_STR;
						push_result(v, KIND_DATA, ERR_NONE, 1'b1);
					end
				end
			end
			PH_HI0, PH_HI1, PH_HI2, PH_HI3: begin
				if (h < 0) raise_error(ERR_BAD_HEX);
				else begin
					hi_unit = {hi_unit[11:0], 4'(h)};
					if (dec_phase != PH_HI3) dec_phase = phase_t'(dec_phase + 1);
					else if (hi_unit >= HI_SURR_MIN && hi_unit <= HI_SURR_MAX)
						dec_phase = PH_BSL;
					else emit_code_point({5'b00000, hi_unit});
				end
			end
			PH_BSL: begin
				if (eoi || c != CH_BACKSLASH) raise_error(ERR_BAD_SURR);
				else dec_phase = PH_U;
			end
			PH_U: begin
				if (eoi || c != CH_U) raise_error(ERR_BAD_SURR);
				else begin
					lo_unit   = '0;
					dec_phase = PH_LO0;
				end
			end
			PH_LO0, PH_LO1, PH_LO2, PH_LO3: begin
				if (h < 0) raise_error(ERR_BAD_HEX);
				else begin
					lo_unit = {lo_unit[11:0], 4'(h)};
					if (dec_phase != PH_LO3) dec_phase = phase_t'(dec_phase + 1);
					else if (lo_unit < LO_SURR_MIN || lo_unit > LO_SURR_MAX)
						raise_error(ERR_BAD_LOW);
					else begin
						// join the pair into a supplementary code point
						hi_off = 21'(hi_unit - HI_SURR_MIN);
						emit_code_point(PAIR_BASE + ((hi_off << 10) |
							21'(lo_unit - LO_SURR_MIN)));
					end
				end
			end
			default: begin
				// idle: only an opening quote is accepted
				if (eoi || c != CH_QUOTE) raise_error(ERR_NO_QUOTE);
				else begin
					dec_phase = PH_STR;
					hi_unit   = '0;
					lo_unit   = '0;
				end
			end
		endcase
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// compare one result transfer against the oldest prediction
	task automatic check_result();
		decoded_t want;
		if (decoded_q.size() == 0) begin
			$error("result with nothing predicted: out_byte %0h kind %0d error_code %0d",
				res_ch.out_byte, res_ch.kind, res_ch.error_code);
			mismatches++;
		end else begin
			want = decoded_q.pop_front();
			check_field("out_byte", want.data, res_ch.out_byte);
			check_field("kind", 8'(want.kind), 8'(res_ch.kind));
			check_field("error_code", 8'(want.code), 8'(res_ch.error_code));
			check_field("last", 8'(want.last), 8'(res_ch.last));
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_phase = PH_IDLE;
			hi_unit   = '0;
			lo_unit   = '0;
			decoded_q.delete();
			pending   = 0;
		end else begin
			if (text_ch.valid && text_ch.ready)
				decode_byte(text_ch.text_byte, text_ch.end_of_input);
			if (res_ch.valid && res_ch.ready)
				check_result();
			pending = decoded_q.size();
		end
	end

endmodule

// ----- dv/json_string_unescape_core_tb.sv -----
// json_string_unescape_core_tb: clock, reset, text stimulus and verdict for the string decoder
`timescale 1ns / 100ps

module json_string_unescape_core_tb;
	import jsu_pkg::*;

	localparam int RANDOM_ITEMS = 420;
	localparam int MAX_WAIT     = 12;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} text_item_t;

	localparam logic [7:0] ESCAPES[8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B,
		CH_F, CH_N, CH_R, CH_T};
	localparam logic [7:0] NOT_ESCAPE[6] = '{"a", "x", "U", "0", " ", 8'h09};
	localparam logic [7:0] NOT_HEX[8] = '{"g", "G", "x", "z", ":", "/", "@", CH_QUOTE};

	logic clk;
	logic arst_n;
	int   pending;
	int   mismatches;
	int   text_sent = 0;
	int   tx_calm   = 0;
	int   rx_calm   = 0;

	text_item_t text_q[$];

	jsu_in_if  text_ch();
	jsu_out_if res_ch();

	json_string_unescape_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (res_ch)
	);

	json_string_unescape_checker decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_ch    (text_ch),
		.res_ch     (res_ch),
		.pending    (pending),
		.mismatches (mismatches)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop if the run hangs
	initial begin
		#3_000_000;
		$display("json_string_unescape_core_tb: done, errors");
		$finish;
	end

	// wait per transfer, with occasional stretches of none at all
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
	endfunction

	// bmp value of 1, 2 or 3 utf-8 bytes, never a high surrogate
	function automatic logic [15:0] bmp_unit();
		logic [15:0] u;
		case ($urandom_range(0, 2))
			0: u = 16'($urandom_range(0, 16'h007F));
			1: u = 16'($urandom_range(16'h0080, 16'h07FF));
			default: u = 16'($urandom_range(16'h0800, 16'hFFFF));
		endcase
		if (u >= HI_SURR_MIN && u <= HI_SURR_MAX) u ^= 16'h4000;
		return u;
	endfunction

	function automatic logic [15:0] high_unit();
		return 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
	endfunction

	task automatic push_byte(logic [7:0] b);
		text_q.push_back('{b, 1'b0});
	endtask

	task automatic push_eoi();
		text_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endtask

	// backslash, u and the first ndig hex digits of u
	task automatic push_unit(logic [15:0] u, int ndig);
		push_byte(CH_BACKSLASH);
		push_byte(CH_U);
		for (int i = 0; i < ndig; i++)
			push_byte(hex_char(u[15 - 4 * i -: 4]));
	endtask

	// one piece of string content; a broken piece ends the string
	task automatic add_piece(output bit broken);
		int          sel;
		logic [7:0]  b;
		logic [15:0] u;
		sel    = $urandom_range(0, 99);
		broken = 1'b0;
		if (sel < 30) begin
			do b = 8'($urandom_range(8'h20, 8'h7F));
			while (b == CH_QUOTE || b == CH_BACKSLASH);
			push_byte(b);
		end else if (sel < 40) begin
			push_byte(8'($urandom_range(8'h80, 8'hFF)));
		end else if (sel < 58) begin
			push_byte(CH_BACKSLASH);
			push_byte(ESCAPES[$urandom_range(0, 7)]);
		end else if (sel < 70) begin
			push_unit(bmp_unit(), 4);
		end else if (sel < 80) begin
			push_unit(high_unit(), 4);
			push_unit(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)), 4);
		end else if (sel < 82) begin
			// lone low surrogate passes as a plain bmp value
			push_unit(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)), 4);
		end else if (sel < 84) begin
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			broken = 1'b1;
			case ($urandom_range(0, 5))
				0: begin
					push_byte(CH_BACKSLASH);
					push_byte(NOT_ESCAPE[$urandom_range(0, 5)]);
				end
				1: push_byte(8'($urandom_range(0, 8'h1F)));
				2: begin
					// bad digit in the first or the low unit
					if ($urandom_range(0, 1)) push_unit(high_unit(), 4);
					push_unit(16'($urandom()), $urandom_range(0, 3));
					push_byte(NOT_HEX[$urandom_range(0, 7)]);
				end
				3: begin
					// high surrogate not followed by \u
					push_unit(high_unit(), 4);
					case ($urandom_range(0, 2))
						0: push_byte("a");
						1: begin
							push_byte(CH_BACKSLASH);
							push_byte(CH_N);
						end
						default: begin
							push_byte(CH_BACKSLASH);
							push_byte("U");
						end
					endcase
				end
				4: begin
					push_unit(high_unit(), 4);
					u = 16'($urandom());
					if (u >= LO_SURR_MIN && u <= LO_SURR_MAX) u ^= 16'h2000;
					push_unit(u, 4);
				end
				default: begin
					// text ends part way through
					case ($urandom_range(0, 5))
						0: ;
						1: push_byte(CH_BACKSLASH);
						2: push_unit(16'($urandom()), $urandom_range(0, 3));
						3: push_unit(high_unit(), 4);
						4: begin
							push_unit(high_unit(), 4);
							push_byte(CH_BACKSLASH);
						end
						default: begin
							push_unit(high_unit(), 4);
							push_unit(16'($urandom()), $urandom_range(0, 3));
						end
					endcase
					push_eoi();
				end
			endcase
		end
	endtask

	task automatic add_string();
		int pieces;
		bit broken;
		broken = 1'b0;
		pieces = $urandom_range(0, 6);
		push_byte(CH_QUOTE);
		for (int i = 0; i < pieces && !broken; i++)
			add_piece(broken);
		if (!broken) push_byte(CH_QUOTE);
	endtask

	// entered at a falling edge, returns at the falling edge after the transfer
	task automatic send_text(text_item_t item);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid        <= 1'b1;
		text_ch.text_byte    <= item.b;
		text_ch.end_of_input <= item.eoi;
		do @(posedge clk); while (!text_ch.ready);
		@(negedge clk);
		text_sent++;
	endtask

	task automatic flush_text();
		while (text_q.size() > 0)
			send_text(text_q.pop_front());
	endtask

	// hold the sender off until every predicted result has left
	task automatic drain_results();
		text_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// result side: random stalls before each transfer
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = draw_wait(rx_calm);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// text side and verdict
	initial begin
		int  random_start;
		bit  drained;
		text_ch.valid        = 1'b0;
		text_ch.text_byte    = 8'h00;
		text_ch.end_of_input = 1'b0;
		arst_n               = 1'b0;
		drained              = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle rejects, control byte, byte extremes and nul, widest pair,
		// lone low surrogate then end of text inside the string
		push_byte("x");
		push_eoi();
		push_byte(CH_QUOTE);
		push_byte(8'h1F);
		push_byte(CH_QUOTE);
		push_byte(8'hFF);
		push_byte(CH_SPACE);
		push_unit(16'h0000, 4);
		push_byte(CH_QUOTE);
		push_byte(CH_QUOTE);
		push_unit(HI_SURR_MAX, 4);
		push_unit(LO_SURR_MAX, 4);
		push_byte(CH_QUOTE);
		push_byte(CH_QUOTE);
		push_unit(LO_SURR_MIN, 4);
		push_eoi();
		flush_text();
		drain_results();

		// random: mostly whole strings, some noise between them
		random_start = text_sent;
		while (text_sent - random_start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) == 0) push_eoi();
					else push_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				add_string();
			end
			flush_text();
			if (!drained && text_sent - random_start >= RANDOM_ITEMS / 2) begin
				drain_results();
				drained = 1'b1;
			end
		end

		// let the last results out, then a few more cycles for strays
		drain_results();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("json_string_unescape_core_tb: done, clean");
		else
			$display("json_string_unescape_core_tb: done, errors");
		$finish;
	end

endmodule
